// ===== hdl/esc_pkg.sv =====
// esc_pkg: shared types and codes for the elevator scan scheduler.
// No dependencies; used by elevator_scan_scheduler_core.
`timescale 1ns / 1ps

package esc_pkg;

  localparam int FLOOR_W = 5;

  typedef logic [FLOOR_W-1:0] floor_t;
  typedef logic [1:0]         op_t;

  localparam op_t OP_CAB  = 2'd0;
  localparam op_t OP_UP   = 2'd1;
  localparam op_t OP_DOWN = 2'd2;
  localparam op_t OP_RUN  = 2'd3;

  localparam floor_t NUM_FLOORS_RST = 5'd16;

endpackage

// ===== hdl/elevator_scan_scheduler_core.sv =====
// Elevator SCAN scheduler: pending request sets plus a one-floor-per-cycle sweep sequencer.
// Depends on esc_pkg.
// Request words only set pending bits. For a run word, one floor of the three sweeps is
// checked per cycle by the shared visit compare unless the output is stalled, then the
// held final word is flushed, with in_ready low. Words leave through one output register.
// Sync reset (rst_n low) clears all pending sets and sets num_floors to 16.
`timescale 1ns / 1ps

module elevator_scan_scheduler_core #(
  parameter int MAX_FLOORS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  esc_pkg::floor_t       cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  esc_pkg::op_t          in_op,
  input  esc_pkg::floor_t       in_floor,
  output logic                  out_valid,
  input  logic                  out_ready,
  output esc_pkg::floor_t       out_visited_floor,
  output logic                  out_last
);

  localparam int IDX_W   = (MAX_FLOORS > 1) ? $clog2(MAX_FLOORS) : 1;
  localparam int TOP_CAP = (MAX_FLOORS > 31) ? 31 : MAX_FLOORS;
  localparam esc_pkg::floor_t TOP_CAP_F = esc_pkg::FLOOR_W'(TOP_CAP);
  localparam esc_pkg::floor_t FLOOR_ONE = esc_pkg::FLOOR_W'(1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [1:0]            phase_r, phase_nxt;
  esc_pkg::floor_t       pos_r, pos_nxt;
  esc_pkg::floor_t       cur_r, cur_nxt;
  esc_pkg::floor_t       top_r, top_nxt;
  logic                  first_up_r, first_up_nxt;
  esc_pkg::floor_t       num_floors_r, num_floors_nxt;
  logic [MAX_FLOORS-1:0] cab_r, cab_nxt;
  logic [MAX_FLOORS-1:0] up_r, up_nxt;
  logic [MAX_FLOORS-1:0] dn_r, dn_nxt;
  esc_pkg::floor_t       hold_r, hold_nxt;
  logic                  out_valid_r, out_valid_nxt;
  esc_pkg::floor_t       out_floor_r, out_floor_nxt;
  logic                  out_last_r, out_last_nxt;

  esc_pkg::floor_t       top_eff, run_cur, target;
  logic [IDX_W-1:0]      req_idx, pos_idx;
  logic                  req_ok, dir_up, hit_cab, hit_call, serve, out_free, advance;

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_visited_floor = out_floor_r;
  assign out_last          = out_last_r;
  assign out_free          = !out_valid_r || out_ready;

  // sweep top clamped into 1..min(MAX_FLOORS, 31); run start floor clamped into 1..top
  always_comb begin
    if (num_floors_r == '0) begin
      top_eff = FLOOR_ONE;
    end else if (num_floors_r > TOP_CAP_F) begin
      top_eff = TOP_CAP_F;
    end else begin
      top_eff = num_floors_r;
    end
    if (in_floor < FLOOR_ONE) begin
      run_cur = FLOOR_ONE;
    end else if (in_floor > top_eff) begin
      run_cur = top_eff;
    end else begin
      run_cur = in_floor;
    end
  end

  assign req_ok  = (in_floor >= FLOOR_ONE) && (in_floor <= TOP_CAP_F);
  assign req_idx = IDX_W'(in_floor - FLOOR_ONE);
  assign pos_idx = IDX_W'(pos_r - FLOOR_ONE);

  // sweep direction and end floor for the current phase
  always_comb begin
    dir_up = first_up_r ? (phase_r != PH_SECOND) : (phase_r == PH_SECOND);
    unique case (phase_r)
      PH_FIRST:  target = first_up_r ? top_r : FLOOR_ONE;
      PH_SECOND: target = first_up_r ? FLOOR_ONE : top_r;
      default:   target = cur_r;
    endcase
  end

  // shared visit unit: one floor checked per cycle unless the output is stalled
  assign hit_cab  = cab_r[pos_idx];
  assign hit_call = dir_up ? up_r[pos_idx] : dn_r[pos_idx];
  assign serve    = hit_cab || hit_call;
  assign advance  = !serve || out_free;

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    pos_nxt        = pos_r;
    cur_nxt        = cur_r;
    top_nxt        = top_r;
    first_up_nxt   = first_up_r;
    num_floors_nxt = num_floors_r;
    cab_nxt        = cab_r;
    up_nxt         = up_r;
    dn_nxt         = dn_r;
    hold_nxt       = hold_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_floor_nxt  = out_floor_r;
    out_last_nxt   = out_last_r;

    if (cfg_wr_en) begin
      num_floors_nxt = cfg_wr_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == esc_pkg::OP_RUN) begin
            // starting floor waits in hold until we know whether it is the last word
            hold_nxt     = run_cur;
            cur_nxt      = run_cur;
            top_nxt      = top_eff;
            pos_nxt      = run_cur;
            phase_nxt    = PH_FIRST;
            first_up_nxt = ((run_cur - FLOOR_ONE) >= (top_eff - run_cur));
            state_nxt    = ST_SWEEP;
          end else if (req_ok) begin
            unique case (in_op)
              esc_pkg::OP_CAB: cab_nxt[req_idx] = 1'b1;
              esc_pkg::OP_UP:  up_nxt[req_idx]  = 1'b1;
              default:         dn_nxt[req_idx]  = 1'b1;
            endcase
          end
        end
      end
      ST_SWEEP: begin
        if (advance) begin
          if (serve) begin
            out_valid_nxt = 1'b1;
            out_floor_nxt = hold_r;
            out_last_nxt  = 1'b0;
            hold_nxt      = pos_r;
            if (hit_cab) begin
              cab_nxt[pos_idx] = 1'b0;
            end else if (dir_up) begin
              up_nxt[pos_idx] = 1'b0;
            end else begin
              dn_nxt[pos_idx] = 1'b0;
            end
          end
          if (pos_r == target) begin
            // next sweep starts again at the turning floor
            if (phase_r == PH_THIRD) begin
              state_nxt = ST_FLUSH;
            end else begin
              phase_nxt = phase_r + 2'd1;
            end
          end else if (dir_up) begin
            pos_nxt = pos_r + FLOOR_ONE;
          end else begin
            pos_nxt = pos_r - FLOOR_ONE;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_floor_nxt = hold_r;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_r      <= PH_FIRST;
      pos_r        <= '0;
      first_up_r   <= 1'b0;
      num_floors_r <= esc_pkg::NUM_FLOORS_RST;
      cab_r        <= '0;
      up_r         <= '0;
      dn_r         <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      pos_r        <= pos_nxt;
      first_up_r   <= first_up_nxt;
      num_floors_r <= num_floors_nxt;
      cab_r        <= cab_nxt;
      up_r         <= up_nxt;
      dn_r         <= dn_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    top_r       <= top_nxt;
    hold_r      <= hold_nxt;
    out_floor_r <= out_floor_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

// ===== dv/elevator_scan_scheduler_core_test.sv =====
// Self-checking testbench for elevator_scan_scheduler_core: directed and random request/run
// words against a built-in SCAN order predictor, with random valid/ready gaps on both sides.
// Depends on esc_pkg and the elevator_scan_scheduler_core RTL.
`timescale 1ns / 1ps

module elevator_scan_scheduler_core_test;

  localparam int FLOORS      = 16;
  localparam int SETTLE      = 2 * FLOORS + 10;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    esc_pkg::floor_t visited;
    logic            last;
  } stop_t;

  // Tracks pending requests and the floor order each run word should produce.
  class floor_order_scoreboard;
    logic [FLOORS-1:0] cab_pend;
    logic [FLOORS-1:0] up_pend;
    logic [FLOORS-1:0] down_pend;
    esc_pkg::floor_t   top_reg;
    stop_t             expected_stops[$];
    int                errors;

    function new();
      cab_pend  = '0;
      up_pend   = '0;
      down_pend = '0;
      top_reg   = esc_pkg::NUM_FLOORS_RST;
      errors    = 0;
    endfunction

    function void set_top(esc_pkg::floor_t v);
      top_reg = v;
    endfunction

    function void add_stop(stop_t s);
      expected_stops = {expected_stops, s};
    endfunction

    function void serve(int f, bit upward);
      stop_t s;
      s.visited = esc_pkg::floor_t'(f);
      s.last    = 1'b0;
      if (cab_pend[f-1]) begin
        cab_pend[f-1] = 1'b0;
        add_stop(s);
      end else if (upward && up_pend[f-1]) begin
        up_pend[f-1] = 1'b0;
        add_stop(s);
      end else if (!upward && down_pend[f-1]) begin
        down_pend[f-1] = 1'b0;
        add_stop(s);
      end
    endfunction

    function void sweep(int from, int to, bit upward);
      if (upward) begin
        for (int f = from; f <= to; f++) serve(f, 1'b1);
      end else begin
        for (int f = from; f >= to; f--) serve(f, 1'b0);
      end
    endfunction

    function void note_word(esc_pkg::op_t op, esc_pkg::floor_t fl);
      int    top;
      int    cur;
      stop_t s;
      if (op != esc_pkg::OP_RUN) begin
        if (fl < 1 || fl > FLOORS) return;
        case (op)
          esc_pkg::OP_CAB: cab_pend[fl-1] = 1'b1;
          esc_pkg::OP_UP:  up_pend[fl-1] = 1'b1;
          default:         down_pend[fl-1] = 1'b1;
        endcase
        return;
      end
      top = (top_reg < 1) ? 1 : (top_reg > FLOORS) ? FLOORS : int'(top_reg);
      cur = (fl < 1) ? 1 : (fl > top) ? top : int'(fl);
      s.visited = esc_pkg::floor_t'(cur);
      s.last    = 1'b0;
      add_stop(s);
      if (cur - 1 >= top - cur) begin
        sweep(cur, top, 1'b1);
        sweep(top, 1, 1'b0);
        sweep(1, cur, 1'b1);
      end else begin
        sweep(cur, 1, 1'b0);
        sweep(1, top, 1'b1);
        sweep(top, cur, 1'b0);
      end
      expected_stops[expected_stops.size()-1].last = 1'b1;
    endfunction

    function void check_word(esc_pkg::floor_t visited, logic last);
      stop_t exp_s;
      if (expected_stops.size() == 0) begin
        $error("unexpected word: visited_floor %0d last %0d", visited, last);
        errors++;
        return;
      end
      exp_s = expected_stops.pop_front();
      if (visited !== exp_s.visited) begin
        $error("visited_floor: expected %0d, actual %0d", exp_s.visited, visited);
        errors++;
      end
      if (last !== exp_s.last) begin
        $error("last: expected %0d, actual %0d", exp_s.last, last);
        errors++;
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst_n;
  logic            cfg_wr_en;
  esc_pkg::floor_t cfg_wr_data;
  logic            in_valid;
  logic            in_ready;
  esc_pkg::op_t    in_op;
  esc_pkg::floor_t in_floor;
  logic            out_valid;
  logic            out_ready;
  esc_pkg::floor_t out_visited_floor;
  logic            out_last;

  floor_order_scoreboard sb;
  bit quiet;
  int stall_cycles;

  elevator_scan_scheduler_core #(
    .MAX_FLOORS(FLOORS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_floor         (in_floor),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_visited_floor(out_visited_floor),
    .out_last         (out_last)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_ready = quiet || ($urandom_range(99) >= 32);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_word(out_visited_floor, out_last);
  end

  // Watchdog: cycles in a row with no word moving on any port.
  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Called right after a posedge; valid stays up across back-to-back words.
  task automatic send_word(esc_pkg::op_t op, esc_pkg::floor_t fl);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 32) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_op    = op;
    in_floor = fl;
    do @(posedge clk); while (!in_ready);
    sb.note_word(op, fl);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_stops.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_top(esc_pkg::floor_t v);
    drain();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    sb.set_top(v);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic send_random();
    esc_pkg::op_t    op;
    esc_pkg::floor_t fl;
    if ($urandom_range(99) < 15) begin
      op = esc_pkg::OP_RUN;
      fl = ($urandom_range(9) == 0) ? esc_pkg::floor_t'($urandom_range(31)) :
                                      esc_pkg::floor_t'($urandom_range(FLOORS, 1));
    end else begin
      op = esc_pkg::op_t'($urandom_range(2));
      fl = ($urandom_range(9) == 0) ? esc_pkg::floor_t'($urandom_range(31)) :
                                      esc_pkg::floor_t'($urandom_range(FLOORS, 1));
    end
    send_word(op, fl);
  endtask

  initial begin
    esc_pkg::floor_t tops[6];
    sb          = new();
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_op       = esc_pkg::OP_CAB;
    in_floor    = '0;
    quiet       = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed: full-height building from reset
    send_word(esc_pkg::OP_CAB, 5'd1);
    send_word(esc_pkg::OP_UP, 5'd16);
    send_word(esc_pkg::OP_DOWN, 5'd8);
    send_word(esc_pkg::OP_UP, 5'd8);      // same floor called both ways
    send_word(esc_pkg::OP_CAB, 5'd16);
    send_word(esc_pkg::OP_DOWN, 5'd1);
    send_word(esc_pkg::OP_CAB, 5'd0);     // out of range, dropped
    send_word(esc_pkg::OP_UP, 5'd31);
    send_word(esc_pkg::OP_DOWN, 5'd17);
    send_word(esc_pkg::OP_RUN, 5'd0);     // clamps to floor 1
    send_word(esc_pkg::OP_RUN, 5'd31);    // clamps to the top
    send_word(esc_pkg::OP_RUN, 5'd5);     // nothing pending
    send_word(esc_pkg::OP_CAB, 5'd8);
    send_word(esc_pkg::OP_UP, 5'd3);
    send_word(esc_pkg::OP_DOWN, 5'd12);
    send_word(esc_pkg::OP_RUN, 5'd9);
    send_word(esc_pkg::OP_RUN, 5'd8);

    // short building: request above the top waits
    write_top(5'd4);
    send_word(esc_pkg::OP_UP, 5'd10);
    send_word(esc_pkg::OP_CAB, 5'd2);
    send_word(esc_pkg::OP_RUN, 5'd2);
    send_word(esc_pkg::OP_RUN, 5'd4);
    write_top(5'd0);             // behaves as a single floor
    send_word(esc_pkg::OP_CAB, 5'd1);
    send_word(esc_pkg::OP_RUN, 5'd7);
    write_top(5'd31);            // clamps to the full height
    send_word(esc_pkg::OP_RUN, 5'd16);

    tops = '{5'd16, 5'd9, 5'd1, 5'd17, 5'd2, 5'd31};
    foreach (tops[i]) begin
      write_top(tops[i]);
      quiet = (i == 3);
      repeat (26) send_random();
      send_word(esc_pkg::OP_RUN, esc_pkg::floor_t'($urandom_range(FLOORS, 1)));
    end
    quiet = 1'b0;

    drain();
    if (sb.errors == 0 && sb.expected_stops.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
